/* rtl/acs_pkg.sv */
package acs_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int PC_WIDTH_DEF   = 7;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0] JUMP_LIMIT_RESET = 8'd10;

    localparam logic [3:0] OP_NOP = 4'd0;
    localparam logic [3:0] OP_VAR = 4'd1;
    localparam logic [3:0] OP_HLT = 4'd2;
    localparam logic [3:0] OP_LOD = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_ADX = 4'd5;
    localparam logic [3:0] OP_SUB = 4'd6;
    localparam logic [3:0] OP_SBX = 4'd7;
    localparam logic [3:0] OP_MUL = 4'd8;
    localparam logic [3:0] OP_MLX = 4'd9;
    localparam logic [3:0] OP_DIV = 4'd10;
    localparam logic [3:0] OP_DVX = 4'd11;
    localparam logic [3:0] OP_MOD = 4'd12;
    localparam logic [3:0] OP_MDX = 4'd13;
    localparam logic [3:0] OP_STO = 4'd14;
    localparam logic [3:0] OP_JMP = 4'd15;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_HALT,
        CLS_LOAD,
        CLS_ADDSUB,
        CLS_MUL,
        CLS_DIV,
        CLS_STORE,
        CLS_JUMP
    } op_class_t;

    typedef struct packed {
        op_class_t  cls;
        logic       use_acc;
        logic       is_sub;
        logic       want_rem;
    } op_ctrl_t;

endpackage

/* rtl/accumulator_cpu_step.sv */
// Accumulator machine step unit. Input words arrive on s_axis_* (tuser =
// kind[3:0]; tdata = operand[6:0], data_value[38:7]); one result word leaves
// on m_axis_* per input word. The jump limit is written through
// cfg_valid/cfg_ready/cfg_data; the user must do so only while idle, which
// the block does not enforce. A front stage decodes each word into a
// two-entry queue; the back stage executes it. Simple ops and zero divides
// finish in the idle state; multiply runs MUL, DIVFX; divide and modulo run
// DIV on the shared divider (one quotient bit per cycle), DIVFX; STO runs
// STO (one byte of the magnitude folded into the remainder mod 100 per
// cycle), OUT. A word leaves the queue only once the last result is
// accepted. Reset clears PC, X, accumulator, jump count and halt flag and
// sets the jump limit to 10. When m_axis_tready is low the result holds and
// the back stage stalls; the queue keeps taking input words until full.
module accumulator_cpu_step
    import acs_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int PC_WIDTH   = PC_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [3:0]   s_axis_tuser, // kind
    input  logic [((7+DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata, // operand, data_value
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // program_counter, accumulator_out, halted, store_valid, stored_value,
    // divide_error, jump_taken
    output logic [((PC_WIDTH+DATA_WIDTH+11+7)/8)*8-1:0] m_axis_tdata
);

    localparam int OW = ((PC_WIDTH+DATA_WIDTH+11+7)/8)*8;

    logic [7:0]            jlim_reg;
    logic                  q_valid, q_ready;
    op_ctrl_t              q_ctrl;
    logic [6:0]            q_operand;
    logic [DATA_WIDTH-1:0] q_data, acc;
    logic [PC_WIDTH-1:0]   pc;
    logic                  halted, sv, derr, jt;
    logic [6:0]            stored;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jlim_reg <= JUMP_LIMIT_RESET;
        end else if (cfg_valid) begin
            jlim_reg <= cfg_data;
        end
    end

    acs_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_kind    (s_axis_tuser),
        .in_operand (s_axis_tdata[6:0]),
        .in_data    (s_axis_tdata[7 +: DATA_WIDTH]),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_ctrl     (q_ctrl),
        .q_operand  (q_operand),
        .q_data     (q_data)
    );

    acs_back #(.DATA_WIDTH(DATA_WIDTH), .PC_WIDTH(PC_WIDTH)) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .jump_limit      (jlim_reg),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_ctrl          (q_ctrl),
        .q_operand       (q_operand),
        .q_data          (q_data),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_pc          (pc),
        .out_acc         (acc),
        .out_halted      (halted),
        .out_store_valid (sv),
        .out_stored      (stored),
        .out_div_err     (derr),
        .out_jump_taken  (jt)
    );

    assign m_axis_tdata = OW'({jt, derr, stored, sv, halted, acc, pc});

endmodule

/* rtl/acs_front.sv */
module acs_front
    import acs_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [3:0]            in_kind,
    input  logic [6:0]            in_operand,
    input  logic [DATA_WIDTH-1:0] in_data,
    output logic                  q_valid,
    input  logic                  q_ready,
    output op_ctrl_t              q_ctrl,
    output logic [6:0]            q_operand,
    output logic [DATA_WIDTH-1:0] q_data
);

    localparam int EW = $bits(op_ctrl_t) + 7 + DATA_WIDTH;
    localparam int AW = $clog2(QUEUE_DEPTH);

    op_ctrl_t         ctrl;
    logic [EW-1:0]    mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             push, pop;
    logic [EW-1:0]    head;

    always_comb begin
        ctrl = '{cls: CLS_NONE, use_acc: in_kind[0], is_sub: 1'b0,
                 want_rem: (in_kind == OP_MOD) || (in_kind == OP_MDX)};
        unique case (in_kind)
            OP_HLT:                 ctrl.cls = CLS_HALT;
            OP_LOD:                 ctrl.cls = CLS_LOAD;
            OP_ADD, OP_ADX:         ctrl.cls = CLS_ADDSUB;
            OP_SUB, OP_SBX: begin
                ctrl.cls    = CLS_ADDSUB;
                ctrl.is_sub = 1'b1;
            end
            OP_MUL, OP_MLX:         ctrl.cls = CLS_MUL;
            OP_DIV, OP_DVX, OP_MOD, OP_MDX: ctrl.cls = CLS_DIV;
            OP_STO:                 ctrl.cls = CLS_STORE;
            OP_JMP:                 ctrl.cls = CLS_JUMP;
            default:                ctrl.cls = CLS_NONE;
        endcase
    end

    assign in_ready = (cnt_reg != (AW+1)'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_valid && q_ready;
    assign head     = mem_reg[rd_reg];
    assign {q_ctrl, q_operand, q_data} = head;

    always_comb begin
        wr_next  = push ? AW'((32'(wr_reg) + 1) % QUEUE_DEPTH) : wr_reg;
        rd_next  = pop  ? AW'((32'(rd_reg) + 1) % QUEUE_DEPTH) : rd_reg;
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= {ctrl, in_operand, in_data};
        end
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* rtl/acs_divider.sv */
module acs_divider
    import acs_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic [DATA_WIDTH-1:0] remainder
);

    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] q_reg, d_reg, r_reg;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   shifted;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg, done_reg;

    assign shifted   = {r_reg, q_reg[DATA_WIDTH-1]};
    assign trial     = shifted - {1'b0, d_reg};
    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            d_reg <= divisor;
            r_reg <= '0;
        end else if (busy_reg) begin
            if (!trial[DATA_WIDTH]) begin
                r_reg <= trial[DATA_WIDTH-1:0];
                q_reg <= {q_reg[DATA_WIDTH-2:0], 1'b1};
            end else begin
                r_reg <= shifted[DATA_WIDTH-1:0];
                q_reg <= {q_reg[DATA_WIDTH-2:0], 1'b0};
            end
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DATA_WIDTH - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/acs_back.sv */
module acs_back
    import acs_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int PC_WIDTH   = PC_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [7:0]            jump_limit,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  op_ctrl_t              q_ctrl,
    input  logic [6:0]            q_operand,
    input  logic [DATA_WIDTH-1:0] q_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PC_WIDTH-1:0]   out_pc,
    output logic [DATA_WIDTH-1:0] out_acc,
    output logic                  out_halted,
    output logic                  out_store_valid,
    output logic [6:0]            out_stored,
    output logic                  out_div_err,
    output logic                  out_jump_taken
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_DIVFX = 3'd3;
    localparam logic [2:0] ST_STO   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [7:0]  HUNDRED     = 8'd100;
    localparam logic [15:0] RECIP_100   = 16'd41944;
    localparam int          RECIP_SHIFT = 22;
    localparam int          NB          = (DATA_WIDTH + 7) / 8;
    localparam int          MW          = NB * 8;
    localparam int          BCW         = (NB > 1) ? $clog2(NB) : 1;

    logic [2:0]            st_reg;
    logic [PC_WIDTH-1:0]   pc_reg;
    logic [DATA_WIDTH-1:0] x_reg, acc_reg, a_reg, b_reg, prod_reg;
    logic [7:0]            jcnt_reg;
    logic                  halt_reg, sv_reg, derr_reg, jt_reg, rem_reg, na_reg, nb_reg;
    logic [6:0]            stored_reg, digit_reg;
    logic [MW-1:0]         mag_reg;
    logic [BCW-1:0]        byte_cnt_reg;
    logic [PC_WIDTH-1:0]   pc_inc;
    logic [DATA_WIDTH-1:0] src, mag_a, mag_b, div_q, div_r, qfix, rfix, acc_mag;
    logic                  div_done, take, jump_ok, div_ok;
    logic                  is_mul, is_div, is_sto, is_jmp;
    logic [14:0]           fold;
    logic [8:0]            fold_q;
    logic [6:0]            digit_next;

    assign q_ready = (st_reg == ST_IDLE) && !out_valid;
    assign take    = q_valid && q_ready;
    assign pc_inc  = pc_reg + 1'b1;
    assign src     = q_ctrl.use_acc ? acc_reg : x_reg;
    assign mag_a   = src[DATA_WIDTH-1] ? -src : src;
    assign mag_b   = q_data[DATA_WIDTH-1] ? -q_data : q_data;
    assign acc_mag = acc_reg[DATA_WIDTH-1] ? -acc_reg : acc_reg;
    assign qfix    = (na_reg != nb_reg) ? -div_q : div_q;
    assign rfix    = na_reg ? -div_r : div_r;
    assign jump_ok = (jcnt_reg < jump_limit);
    assign div_ok  = (q_data != '0);
    assign is_mul  = (q_ctrl.cls == CLS_MUL);
    assign is_div  = (q_ctrl.cls == CLS_DIV);
    assign is_sto  = (q_ctrl.cls == CLS_STORE);
    assign is_jmp  = (q_ctrl.cls == CLS_JUMP);

    acs_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (take && is_div && div_ok),
        .dividend  (mag_a),
        .divisor   (mag_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // fold one byte of the magnitude per cycle into the remainder mod 100
    assign fold       = {digit_reg, mag_reg[MW-1 -: 8]};
    assign fold_q     = 9'((31'(fold) * 31'(RECIP_100)) >> RECIP_SHIFT);
    assign digit_next = 7'(fold - 15'(fold_q) * 15'(HUNDRED));

    assign out_pc          = pc_reg;
    assign out_acc         = acc_reg;
    assign out_halted      = halt_reg;
    assign out_store_valid = sv_reg;
    assign out_stored      = stored_reg;
    assign out_div_err     = derr_reg;
    assign out_jump_taken  = jt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            out_valid <= 1'b0;
            pc_reg    <= '0;
            x_reg     <= '0;
            acc_reg   <= '0;
            jcnt_reg  <= '0;
            halt_reg  <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                out_valid <= 1'b0;
            end
            unique case (st_reg)
                ST_IDLE: begin
                    if (take) begin
                        pc_reg     <= (is_jmp && jump_ok) ? PC_WIDTH'(q_operand) : pc_inc;
                        sv_reg     <= is_sto;
                        stored_reg <= '0;
                        derr_reg   <= is_div && !div_ok;
                        jt_reg     <= is_jmp && jump_ok;
                        a_reg      <= src;
                        b_reg      <= q_data;
                        rem_reg    <= q_ctrl.want_rem;
                        na_reg     <= src[DATA_WIDTH-1];
                        nb_reg     <= q_data[DATA_WIDTH-1];
                        out_valid  <= !(is_mul || is_sto || (is_div && div_ok));
                        unique case (q_ctrl.cls)
                            CLS_HALT: halt_reg <= 1'b1;
                            CLS_LOAD: x_reg <= q_data;
                            CLS_ADDSUB: acc_reg <= q_ctrl.is_sub ? src - q_data
                                                                 : src + q_data;
                            CLS_MUL: st_reg <= ST_MUL;
                            CLS_DIV: begin
                                if (div_ok) begin
                                    st_reg <= ST_DIV;
                                end
                            end
                            CLS_STORE: begin
                                mag_reg      <= MW'(acc_mag);
                                digit_reg    <= '0;
                                byte_cnt_reg <= BCW'(NB - 1);
                                acc_reg      <= '0;
                                st_reg       <= ST_STO;
                            end
                            CLS_JUMP: begin
                                if (jump_ok) begin
                                    jcnt_reg <= jcnt_reg + 1'b1;
                                end else begin
                                    jcnt_reg <= '0;
                                    halt_reg <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MUL: begin
                    prod_reg <= a_reg * b_reg;
                    st_reg   <= ST_DIVFX;
                    rem_reg  <= 1'b0;
                    derr_reg <= 1'b1;
                end
                ST_DIV: begin
                    if (div_done) begin
                        st_reg <= ST_DIVFX;
                    end
                end
                ST_DIVFX: begin
                    if (derr_reg) begin
                        acc_reg  <= prod_reg;
                        derr_reg <= 1'b0;
                    end else begin
                        acc_reg <= rem_reg ? rfix : qfix;
                    end
                    out_valid <= 1'b1;
                    st_reg    <= ST_IDLE;
                end
                ST_STO: begin
                    digit_reg <= digit_next;
                    mag_reg   <= mag_reg << 8;
                    if (byte_cnt_reg == '0) begin
                        st_reg <= ST_OUT;
                    end else begin
                        byte_cnt_reg <= byte_cnt_reg - 1'b1;
                    end
                end
                ST_OUT: begin
                    stored_reg <= digit_reg;
                    out_valid  <= 1'b1;
                    st_reg     <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

/* tb/tb_accumulator_cpu_step.sv */
`timescale 1ns / 100ps

module tb_accumulator_cpu_step;
    import acs_pkg::*;

    localparam int DW = 32;
    localparam int PW = 7;
    localparam int SW = ((7 + DW + 7) / 8) * 8;
    localparam int MW = ((PW + DW + 11 + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic        jump_taken;
        logic        div_err;
        logic [6:0]  stored;
        logic        store_valid;
        logic        halted;
        logic [31:0] acc;
        logic [6:0]  pc;
    } step_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [3:0] s_axis_tuser = '0;
    logic [SW-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [MW-1:0] m_axis_tdata;

    accumulator_cpu_step dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),   // kind
        .s_axis_tdata  (s_axis_tdata),   // operand, data_value
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // pc, acc, halted, store_valid, stored_value, divide_error, jump_taken
        .m_axis_tdata  (m_axis_tdata)
    );

    // machine state mirror
    logic [7:0]  lim;
    logic [6:0]  pc_q;
    logic [31:0] x_q, acc_q;
    logic [7:0]  jcount;
    logic        halt_q;
    step_result_t expected_results[$];

    int errors = 0;
    int idle_cycles = 0;
    bit rx_free = 1'b0;
    bit rx_hold = 1'b0;
    bit tx_free = 1'b0;

    initial forever #5 aclk = ~aclk;

    function automatic logic [31:0] mag(logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    task automatic execute_instr(logic [3:0] kind, logic [6:0] opnd, logic [31:0] d);
        step_result_t r;
        logic [31:0] a, qa, qr, ua, ub;
        r = '0;
        pc_q = pc_q + 7'd1;
        case (kind)
            OP_HLT: halt_q = 1'b1;
            OP_LOD: x_q = d;
            OP_ADD: acc_q = x_q + d;
            OP_ADX: acc_q = acc_q + d;
            OP_SUB: acc_q = x_q - d;
            OP_SBX: acc_q = acc_q - d;
            OP_MUL: acc_q = x_q * d;
            OP_MLX: acc_q = acc_q * d;
            OP_DIV, OP_DVX, OP_MOD, OP_MDX: begin
                a = kind[0] ? acc_q : x_q;
                if (d == 0) begin
                    r.div_err = 1'b1;
                end else begin
                    ua = mag(a);
                    ub = mag(d);
                    qa = ua / ub;
                    qr = ua % ub;
                    if (a[31] != d[31]) qa = -qa;
                    if (a[31]) qr = -qr;
                    acc_q = (kind >= OP_MOD) ? qr : qa;
                end
            end
            OP_STO: begin
                r.stored = 7'(mag(acc_q) % 100);
                r.store_valid = 1'b1;
                acc_q = '0;
            end
            OP_JMP: begin
                if (jcount < lim) begin
                    pc_q = opnd;
                    jcount = jcount + 8'd1;
                    r.jump_taken = 1'b1;
                end else begin
                    jcount = '0;
                    halt_q = 1'b1;
                end
            end
            default: ;
        endcase
        r.pc = pc_q;
        r.acc = acc_q;
        r.halted = halt_q;
        expected_results.push_back(r);
    endtask

    task automatic send_instr(logic [3:0] kind, logic [6:0] opnd, logic [31:0] d);
        while (!tx_free && $urandom_range(99) < 28) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tuser <= kind;
        s_axis_tdata <= SW'({d, opnd});
        s_axis_tvalid <= 1'b1;
        execute_instr(kind, opnd, d);
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_limit(logic [7:0] v);
        s_axis_tvalid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (50) @(negedge aclk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        lim = v;
    endtask

    function automatic logic [31:0] rand_data();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'(signed'($urandom_range(20)) - 10);
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // receive and compare
    always @(posedge aclk) begin
        step_result_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = step_result_t'(m_axis_tdata[PW+DW+10:0]);
            if (expected_results.size() == 0) begin
                $error("unexpected result word %h", got);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.pc != want.pc) begin
                    $error("program_counter exp %0d got %0d", want.pc, got.pc); errors++;
                end
                if (got.acc != want.acc) begin
                    $error("accumulator_out exp %h got %h", want.acc, got.acc); errors++;
                end
                if (got.halted != want.halted) begin
                    $error("halted exp %b got %b", want.halted, got.halted); errors++;
                end
                if (got.store_valid != want.store_valid) begin
                    $error("store_valid exp %b got %b", want.store_valid, got.store_valid);
                    errors++;
                end
                if (got.stored != want.stored) begin
                    $error("stored_value exp %0d got %0d", want.stored, got.stored); errors++;
                end
                if (got.div_err != want.div_err) begin
                    $error("divide_error exp %b got %b", want.div_err, got.div_err); errors++;
                end
                if (got.jump_taken != want.jump_taken) begin
                    $error("jump_taken exp %b got %b", want.jump_taken, got.jump_taken);
                    errors++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_axis_tready <= !rx_hold && (rx_free || $urandom_range(99) >= 28);
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || expected_results.size() == 0)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_directed();
        logic [3:0] k;
        send_instr(OP_NOP, 7'd0, 32'd5);
        send_instr(OP_VAR, 7'd127, 32'hFFFF_FFFF);
        send_instr(OP_LOD, 7'd0, 32'h7FFF_FFFF);
        send_instr(OP_ADD, 7'd0, 32'd1);
        send_instr(OP_SUB, 7'd0, 32'hFFFF_FFFF);
        send_instr(OP_MUL, 7'd0, 32'h7FFF_FFFF);
        send_instr(OP_ADX, 7'd0, 32'd3);
        send_instr(OP_SBX, 7'd0, 32'd100);
        send_instr(OP_MLX, 7'd0, 32'hFFFF_FFFD);
        send_instr(OP_DIV, 7'd0, 32'd0);
        send_instr(OP_MDX, 7'd0, 32'd0);
        send_instr(OP_STO, 7'd0, 32'd0);
        send_instr(OP_ADX, 7'd0, 32'd7);
        send_instr(OP_STO, 7'd0, 32'd0);
        send_instr(OP_LOD, 7'd0, 32'h8000_0000);
        send_instr(OP_DIV, 7'd0, 32'hFFFF_FFFF);
        send_instr(OP_MOD, 7'd0, 32'hFFFF_FFFF);
        send_instr(OP_ADD, 7'd0, 32'd0);
        send_instr(OP_STO, 7'd0, 32'd0);
        send_instr(OP_ADX, 7'd0, 32'hFFFF_FF85);
        send_instr(OP_DVX, 7'd0, 32'd7);
        send_instr(OP_JMP, 7'd127, 32'd0);
        send_instr(OP_JMP, 7'd0, 32'd0);
        send_instr(OP_HLT, 7'd5, 32'd0);
        for (k = OP_HLT; k != OP_NOP; k++) send_instr(k, 7'($urandom), $urandom);
    endtask

    task automatic test_random_program(int n, bit stall_rx);
        logic [3:0] k;
        if (stall_rx) begin
            fork
                begin
                    rx_hold = 1'b1;
                    repeat (400) @(posedge aclk);
                    rx_hold = 1'b0;
                end
            join_none
        end
        repeat (n) begin
            k = 4'($urandom);
            send_instr(k, 7'($urandom), rand_data());
        end
    endtask

    initial begin
        lim = JUMP_LIMIT_RESET;
        pc_q = '0; x_q = '0; acc_q = '0; jcount = '0; halt_q = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        write_limit(8'd0);
        send_instr(OP_JMP, 7'd9, 32'd0);
        send_instr(OP_JMP, 7'd9, 32'd0);
        write_limit(8'd255);
        test_random_program(150, 1'b1);
        write_limit(8'd3);
        tx_free = 1'b1;
        rx_free = 1'b1;
        test_random_program(150, 1'b0);
        tx_free = 1'b0;
        rx_free = 1'b0;
        write_limit(8'd1);
        test_random_program(150, 1'b0);
        write_limit(8'($urandom));
        test_random_program(150, 1'b0);
        s_axis_tvalid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

/* sim.f */
rtl/acs_pkg.sv
rtl/acs_front.sv
rtl/acs_divider.sv
rtl/acs_back.sv
rtl/accumulator_cpu_step.sv
tb/tb_accumulator_cpu_step.sv
